// ===== rtl/core/height_to_normal_map_top_macros.svh =====
// Assertion macros for the height to normal map block.
// Used by the checker that is bound to the top level; no other dependencies.
`ifndef HEIGHT_TO_NORMAL_MAP_TOP_MACROS_SVH
`define HEIGHT_TO_NORMAL_MAP_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HNM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("height_to_normal_map assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define HNM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("height_to_normal_map assertion failed");

`endif

// ===== rtl/core/hnm_pkg.sv =====
// Shared types and constants of the height to normal map block.
// Used by the arithmetic unit and the top level; no dependencies.
package hnm_pkg;

	// Operand widths of the shared unit
	localparam int OPW  = 19;
	localparam int ACCW = 38;

	// Iteration counts
	localparam int SQRT_STEPS = 19;
	localparam int DIV_STEPS  = 8;

	// Arithmetic constants
	localparam logic [18:0] SCALE = 19'd255;
	localparam logic [18:0] BIAS  = 19'd256;

	// Configuration register indexes
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// Register reset values
	localparam logic [10:0] WIDTH_RESET  = 11'd256;
	localparam logic [15:0] HEIGHT_RESET = 16'd256;

	typedef struct packed {
		logic [OPW-1:0]  mul_a;
		logic [OPW-1:0]  mul_b;
		logic [ACCW-1:0] cmp_a;
		logic [ACCW-1:0] cmp_b;
	} unit_req_t;

	typedef struct packed {
		logic [ACCW-1:0] prod;
		logic            ge;
		logic [ACCW-1:0] diff;
	} unit_rsp_t;

endpackage

// ===== rtl/core/hnm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hnm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/hnm_unit.sv =====
// Shared arithmetic unit: one multiplier and one compare-subtract.
// Depends on hnm_pkg.
module hnm_unit (
	input  hnm_pkg::unit_req_t req,
	output hnm_pkg::unit_rsp_t rsp
);

	// Multiply, compare and subtract
	always_comb begin
		rsp.prod = req.mul_a * req.mul_b;
		rsp.ge   = req.cmp_a >= req.cmp_b;
		rsp.diff = req.cmp_a - req.cmp_b;
	end

endmodule

// ===== rtl/core/height_to_normal_map_top.sv =====
// Height to normal map: top level with sequencer, line buffers and counters.
// Depends on hnm_pkg, hnm_ram and hnm_unit.
//
// Usage:
//   Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
//   (0 = image width, 1 = image height). cfg_ready is always high.
//   Input: in_valid/in_ready carries one item: a pixel (command 0, red,
//   green, blue) or a flush (command 1). Pixels go in raster order.
//   Output: out_valid/out_ready carries normal_x/y/z and last_of_image.
//   Results run one row behind the pixels; after the last row, one flush
//   item per column releases that row.
// Sequence:
//   A pixel of row 0, an ignored pixel or an ignored flush is done on accept.
//   Any other item runs these steps from accept to result: the line buffer
//   reads, 3 multiplies, 19 square root steps, then per component one
//   multiply and 8 restoring divide steps, and the output load.
//   The next item is taken once the sequencer is back in idle after the result.
//   The arithmetic steps share the single multiplier and compare-subtract unit.
//   in_ready is low while an item is at work.
// Reset: counters clear, registers return to 256 x 256, no result pending.
// Line buffers hold no reset value and need no clearing.
// Stall: a result waits in the output register; the sequencer holds its
// last cycle until that register is free.
module height_to_normal_map_top #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  normal_x,
	output logic [7:0]  normal_y,
	output logic [7:0]  normal_z,
	output logic        last_of_image
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD0  = 4'd1;
	localparam logic [3:0] ST_RD1  = 4'd2;
	localparam logic [3:0] ST_RD2  = 4'd3;
	localparam logic [3:0] ST_RD3  = 4'd4;
	localparam logic [3:0] ST_MULA = 4'd5;
	localparam logic [3:0] ST_MULB = 4'd6;
	localparam logic [3:0] ST_MULP = 4'd7;
	localparam logic [3:0] ST_SQRT = 4'd8;
	localparam logic [3:0] ST_NUM  = 4'd9;
	localparam logic [3:0] ST_DIV  = 4'd10;
	localparam logic [3:0] ST_OUT  = 4'd11;

	logic [3:0]  state_q;
	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [XW-1:0] col_q, flush_q, x_q;
	logic [15:0] row_q;
	logic        is_flush_q, first_q, lastc_q, row_gt1_q, last_q;
	logic [7:0]  hcur_q, hl_q, hc_q, hu_q;
	logic signed [10:0] sx_q, sy_q;
	logic [18:0] sqa_q, sqb_q;
	logic [37:0] rem_q, res_q, bit_q;
	logic [4:0]  cnt_q;
	logic [1:0]  comp_q;
	logic [7:0]  quot_q, nx_q, ny_q;
	logic        out_valid_q;
	logic [7:0]  out_x_q, out_y_q, out_z_q;
	logic        out_last_q;

	logic [WW-1:0] weff;
	logic [15:0]   heff;
	logic [7:0]    hmax;
	logic [XW-1:0] x_pix, x_fl, x_in;
	logic          lastc_in;
	logic          in_acc;

	hnm_pkg::unit_req_t ureq;
	hnm_pkg::unit_rsp_t ursp;

	logic          mid_we, up_we;
	logic [XW-1:0] mid_waddr, mid_raddr, up_raddr;
	logic [7:0]    mid_wdata, mid_rdata, up_rdata;

	// Effective image size
	always_comb begin
		if (32'(width_q) < 2) begin
			weff = WW'(2);
		end else if (32'(width_q) > MAX_WIDTH) begin
			weff = WW'(MAX_WIDTH);
		end else begin
			weff = WW'(width_q);
		end
		heff = (height_q < 16'd2) ? 16'd2 : height_q;
	end

	// Height of the incoming pixel and clamped columns
	always_comb begin
		hmax = red;
		if (green > hmax) hmax = green;
		if (blue > hmax) hmax = blue;
		x_pix    = (WW'(col_q) >= weff) ? XW'(weff - WW'(1)) : col_q;
		x_fl     = (WW'(flush_q) >= weff) ? XW'(weff - WW'(1)) : flush_q;
		x_in     = command ? x_fl : x_pix;
		lastc_in = (WW'(x_in) + WW'(1)) >= weff;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Line buffer ports
	always_comb begin
		mid_we    = 1'b0;
		mid_waddr = x_q;
		mid_wdata = hcur_q;
		up_we     = 1'b0;
		mid_raddr = x_q;
		up_raddr  = x_q;
		case (state_q)
			ST_IDLE: begin
				mid_we    = in_acc && !command && (row_q < heff) && (row_q == 16'd0);
				mid_waddr = x_pix;
				mid_wdata = hmax;
			end
			ST_RD0: begin
				mid_raddr = first_q ? x_q : XW'(x_q - XW'(1));
				up_raddr  = mid_raddr;
			end
			ST_RD2: begin
				mid_raddr = lastc_q ? x_q : XW'(x_q + XW'(1));
			end
			ST_RD3: begin
				mid_we = !is_flush_q;
				up_we  = !is_flush_q;
			end
			default: begin
				mid_we = 1'b0;
			end
		endcase
	end

	hnm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_mid_ram (
		.clk   (clk),
		.we    (mid_we),
		.waddr (mid_waddr),
		.wdata (mid_wdata),
		.raddr (mid_raddr),
		.rdata (mid_rdata)
	);

	hnm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_up_ram (
		.clk   (clk),
		.we    (up_we),
		.waddr (x_q),
		.wdata (hc_q),
		.raddr (up_raddr),
		.rdata (up_rdata)
	);

	// Slopes from the gathered neighbors
	logic [7:0]         h_l, h_r, h_y, h_u;
	logic signed [8:0]  dx9, dy9;
	logic signed [10:0] sx_n, sy_n;
	logic               dbl_y;
	always_comb begin
		h_l   = first_q ? hc_q : hl_q;
		h_r   = lastc_q ? hc_q : mid_rdata;
		h_y   = is_flush_q ? hc_q : hcur_q;
		h_u   = (is_flush_q || row_gt1_q) ? hu_q : hc_q;
		dbl_y = is_flush_q || !row_gt1_q;
		dx9   = $signed({1'b0, h_r}) - $signed({1'b0, h_l});
		dy9   = $signed({1'b0, h_y}) - $signed({1'b0, h_u});
		sx_n  = (first_q || lastc_q) ? {dx9[8], dx9, 1'b0} : {{2{dx9[8]}}, dx9};
		sy_n  = dbl_y ? {dy9[8], dy9, 1'b0} : {{2{dy9[8]}}, dy9};
	end

	// Operands for the shared unit
	logic [10:0]        sx_abs, sy_abs;
	logic [18:0]        root;
	logic signed [20:0] num_s;
	logic [19:0]        num_u;
	logic [7:0]         quot_n;
	always_comb begin
		sx_abs = sx_q[10] ? 11'(-sx_q) : sx_q;
		sy_abs = sy_q[10] ? 11'(-sy_q) : sy_q;
		root   = res_q[18:0];
		case (comp_q)
			2'd0:    num_s = $signed({2'b0, root}) - $signed({{6{sx_q[10]}}, sx_q, 4'b0});
			2'd1:    num_s = $signed({2'b0, root}) - $signed({{6{sy_q[10]}}, sy_q, 4'b0});
			default: num_s = $signed({2'b0, root}) + $signed({2'b0, hnm_pkg::BIAS});
		endcase
		num_u = num_s[20] ? 20'd0 : num_s[19:0];

		ureq.mul_a = {8'b0, sx_abs};
		ureq.mul_b = {8'b0, sx_abs};
		ureq.cmp_a = rem_q;
		ureq.cmp_b = res_q + bit_q;
		case (state_q)
			ST_MULB: begin
				ureq.mul_a = {8'b0, sy_abs};
				ureq.mul_b = {8'b0, sy_abs};
			end
			ST_MULP: begin
				ureq.mul_a = sqa_q;
				ureq.mul_b = sqb_q;
			end
			ST_NUM: begin
				ureq.mul_a = 19'(num_u);
				ureq.mul_b = hnm_pkg::SCALE;
			end
			ST_DIV: begin
				ureq.cmp_b = {18'b0, root, 1'b0} << cnt_q;
			end
			default: begin
				ureq.cmp_a = rem_q;
			end
		endcase
		quot_n = {quot_q[6:0], ursp.ge};
	end

	hnm_unit u_unit (
		.req (ureq),
		.rsp (ursp)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= hnm_pkg::WIDTH_RESET;
			height_q <= hnm_pkg::HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hnm_pkg::CFG_WIDTH:  width_q  <= cfg_data[10:0];
				hnm_pkg::CFG_HEIGHT: height_q <= cfg_data;
				default:             height_q <= height_q;
			endcase
		end
	end

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			flush_q <= '0;
			row_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						is_flush_q <= command;
						x_q        <= x_in;
						first_q    <= (x_in == '0);
						lastc_q    <= lastc_in;
						row_gt1_q  <= row_q > 16'd1;
						hcur_q     <= hmax;
						last_q     <= command && lastc_in;
						if (!command && (row_q < heff)) begin
							if (row_q == 16'd0) begin
								// store first row only
								if (lastc_in) begin
									col_q <= '0;
									row_q <= row_q + 16'd1;
								end else begin
									col_q <= XW'(x_in + XW'(1));
								end
							end else begin
								state_q <= ST_RD0;
							end
						end else if (command && (row_q >= heff)) begin
							state_q <= ST_RD0;
						end
					end
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: begin
					hl_q    <= is_flush_q ? mid_rdata : up_rdata;
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					hc_q    <= mid_rdata;
					hu_q    <= up_rdata;
					state_q <= ST_RD3;
				end
				ST_RD3: begin
					sx_q <= sx_n;
					sy_q <= sy_n;
					if (is_flush_q) begin
						if (lastc_q) begin
							col_q   <= '0;
							row_q   <= '0;
							flush_q <= '0;
						end else begin
							flush_q <= XW'(x_q + XW'(1));
						end
					end else if (lastc_q) begin
						col_q <= '0;
						row_q <= row_q + 16'd1;
					end else begin
						col_q <= XW'(x_q + XW'(1));
					end
					state_q <= ST_MULA;
				end
				ST_MULA: begin
					sqa_q   <= hnm_pkg::BIAS + ursp.prod[18:0];
					state_q <= ST_MULB;
				end
				ST_MULB: begin
					sqb_q   <= hnm_pkg::BIAS + ursp.prod[18:0];
					state_q <= ST_MULP;
				end
				ST_MULP: begin
					rem_q   <= ursp.prod;
					res_q   <= '0;
					bit_q   <= 38'd1 << 36;
					cnt_q   <= 5'(hnm_pkg::SQRT_STEPS - 1);
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					// one root digit per cycle
					if (ursp.ge) begin
						rem_q <= ursp.diff;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						comp_q  <= 2'd0;
						state_q <= ST_NUM;
					end
				end
				ST_NUM: begin
					rem_q   <= ursp.prod;
					quot_q  <= '0;
					cnt_q   <= 5'(hnm_pkg::DIV_STEPS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// one quotient bit per cycle
					if (ursp.ge) begin
						rem_q <= ursp.diff;
					end
					quot_q <= quot_n;
					cnt_q  <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						case (comp_q)
							2'd0:    nx_q <= quot_n;
							2'd1:    ny_q <= quot_n;
							default: ;
						endcase
						comp_q  <= comp_q + 2'd1;
						state_q <= (comp_q == 2'd2) ? ST_OUT : ST_NUM;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: load when free, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && (!out_valid_q || out_ready)) begin
			out_x_q    <= nx_q;
			out_y_q    <= ny_q;
			out_z_q    <= quot_q;
			out_last_q <= last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign normal_x      = out_x_q;
	assign normal_y      = out_y_q;
	assign normal_z      = out_z_q;
	assign last_of_image = out_last_q;

endmodule

// ===== rtl/core/hnm_checker.sv =====
// Port-level checker for the height to normal map block, with its bind.
// Depends on height_to_normal_map_top_macros.svh.
`include "height_to_normal_map_top_macros.svh"

module hnm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] normal_x,
	input logic [7:0] normal_y,
	input logic [7:0] normal_z,
	input logic       last_of_image
);

	// Hold a stalled result
	`HNM_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(normal_x) && $stable(normal_y) && $stable(normal_z) && $stable(last_of_image))

	// A new result only comes from a busy sequencer
	`HNM_ASSERT_IMP(a_rise_busy, clk, arst_n, $rose(out_valid), !$past(in_ready))

	// The z component of a unit normal never points below the surface
	`HNM_ASSERT_IMP(a_z_floor, clk, arst_n, out_valid, normal_z >= 8'd127)

endmodule

bind height_to_normal_map_top hnm_checker u_hnm_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for height_to_normal_map_top: directed table, then random images.
// Depends on hnm_pkg and the RTL of the block; carries its own normal map predictor.
`timescale 1ns / 100ps

module tb_top;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;
	localparam int   LINE_MAX  = 1024;
	localparam int   RANDOM_ITEMS = 1100;

	typedef struct {
		logic [7:0] nx;
		logic [7:0] ny;
		logic [7:0] nz;
		logic       last;
	} normal_t;

	typedef struct {
		logic       cmd;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		bit         typed;
		normal_t    res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = 1'b0;
	logic [7:0]  red = '0;
	logic [7:0]  green = '0;
	logic [7:0]  blue = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  normal_x;
	logic [7:0]  normal_y;
	logic [7:0]  normal_z;
	logic        last_of_image;

	// model state of the block
	logic [7:0]  upper_h [LINE_MAX];
	logic [7:0]  middle_h [LINE_MAX];
	int unsigned col_cnt, row_cnt, flush_cnt;
	int unsigned width_reg, height_reg;

	normal_t     pending_normals[$];
	int          err_cnt = 0;
	int          checked_cnt = 0;
	int          sent_cnt = 0;
	int          phase_cnt = 0;
	bit          long_hold_req = 0;
	bit          sender_burst = 0;

	height_to_normal_map_top uut (.*);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint unsigned isqrt(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [7:0] bias_byte(input longint num, input longint q);
		longint v;
		if (num < 0) num = 0;
		v = (255 * num) / (2 * q);
		if (v > 255) v = 255;
		return v[7:0];
	endfunction

	function automatic normal_t make_normal(input longint sx, input longint sy, input logic last);
		normal_t n;
		longint  q;
		q = longint'(isqrt(longint'(256 + sx * sx) * longint'(256 + sy * sy)));
		n.nx = bias_byte(q - 16 * sx, q);
		n.ny = bias_byte(q - 16 * sy, q);
		n.nz = bias_byte(q + 256, q);
		n.last = last;
		return n;
	endfunction

	// advance the model by one item; report whether a normal comes out
	function automatic bit predict_normal(input logic cmd, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, output normal_t n);
		int unsigned w, h, x;
		longint      hc, hl, hr, hu, sx, sy;
		logic [7:0]  m;
		bit          has;
		w = (width_reg < 2) ? 2 : ((width_reg > LINE_MAX) ? LINE_MAX : width_reg);
		h = (height_reg < 2) ? 2 : height_reg;
		has = 0;
		if (cmd == CMD_PIXEL) begin
			m = r;
			if (g > m) m = g;
			if (b > m) m = b;
			if (row_cnt >= h) return 0;
			x = (col_cnt >= w) ? w - 1 : col_cnt;
			hc = m;
			if (row_cnt != 0) begin
				hl = (x > 0) ? upper_h[x - 1] : middle_h[x];
				hr = (x + 1 < w) ? middle_h[x + 1] : middle_h[x];
				hu = (row_cnt > 1) ? upper_h[x] : middle_h[x];
				sx = (x > 0 && x + 1 < w) ? (hr - hl) : 2 * (hr - hl);
				sy = (row_cnt > 1) ? (hc - hu) : 2 * (hc - hu);
				n = make_normal(sx, sy, 1'b0);
				has = 1;
				upper_h[x] = middle_h[x];
			end
			middle_h[x] = m;
			if (x + 1 >= w) begin
				col_cnt = 0;
				row_cnt = (row_cnt + 1) & 16'hFFFF;
			end else begin
				col_cnt = x + 1;
			end
			return has;
		end
		if (row_cnt < h) return 0;
		x = (flush_cnt >= w) ? w - 1 : flush_cnt;
		hc = middle_h[x];
		hl = (x > 0) ? middle_h[x - 1] : hc;
		hr = (x + 1 < w) ? middle_h[x + 1] : hc;
		hu = upper_h[x];
		sx = (x > 0 && x + 1 < w) ? (hr - hl) : 2 * (hr - hl);
		sy = 2 * (hc - hu);
		if (x + 1 >= w) begin
			n = make_normal(sx, sy, 1'b1);
			col_cnt = 0;
			row_cnt = 0;
			flush_cnt = 0;
		end else begin
			n = make_normal(sx, sy, 1'b0);
			flush_cnt = x + 1;
		end
		return 1;
	endfunction

	task automatic write_reg(input logic idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == hnm_pkg::CFG_WIDTH) width_reg = data & 16'h07FF;
		else height_reg = data;
	endtask

	// offer one item, hold it until accepted, then maybe leave a gap
	task automatic send_item(input logic cmd, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input bit typed, input normal_t typed_res);
		normal_t n;
		int      gap, pick;
		in_valid <= 1'b1;
		command <= cmd;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (!in_ready);
		sent_cnt++;
		if (predict_normal(cmd, r, g, b, n)) begin
			pending_normals.push_back(typed ? typed_res : n);
		end
		pick = $urandom_range(0, 99);
		gap = sender_burst ? 0 : (pick < 60) ? 0 : (pick < 90) ? $urandom_range(1, 3)
			: $urandom_range(5, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle;
		in_valid <= 1'b0;
		wait (pending_normals.size() == 0);
		repeat (80) @(posedge clk);
	endtask

	// one full image of random content, with some ignored items mixed in
	task automatic random_image(input int unsigned w, input int unsigned h);
		normal_t     none;
		logic [7:0]  r, g, b;
		int          style;
		none = '{default: '0};
		for (int y = 0; y < h; y++) begin
			for (int x = 0; x < w; x++) begin
				if ($urandom_range(0, 99) < 3) send_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00, 0, none);
				style = $urandom_range(0, 9);
				r = 8'($urandom_range(0, 255));
				g = 8'($urandom_range(0, 255));
				b = 8'($urandom_range(0, 255));
				if (style == 0) begin
					r = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
					g = r;
					b = r;
				end else if (style < 4) begin
					g = r >> 2;
					b = r >> 3;
				end
				send_item(CMD_PIXEL, r, g, b, 0, none);
			end
		end
		if ($urandom_range(0, 99) < 30)
			send_item(CMD_PIXEL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 0, none);
		for (int x = 0; x < w; x++) send_item(CMD_FLUSH, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, none);
	endtask

	// compare each result with the oldest expected normal
	initial begin : result_check
		normal_t exp_n;
		int      stall_left, pick, calm_left;
		stall_left = 0;
		calm_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				checked_cnt++;
				if (pending_normals.size() == 0) begin
					$error("result with no expected item waiting");
					err_cnt++;
				end else begin
					exp_n = pending_normals.pop_front();
					if (normal_x !== exp_n.nx) begin
						$error("normal_x expected %0d actual %0d", exp_n.nx, normal_x);
						err_cnt++;
					end
					if (normal_y !== exp_n.ny) begin
						$error("normal_y expected %0d actual %0d", exp_n.ny, normal_y);
						err_cnt++;
					end
					if (normal_z !== exp_n.nz) begin
						$error("normal_z expected %0d actual %0d", exp_n.nz, normal_z);
						err_cnt++;
					end
					if (last_of_image !== exp_n.last) begin
						$error("last_of_image expected %0d actual %0d", exp_n.last,
							last_of_image);
						err_cnt++;
					end
				end
			end
			pick = $urandom_range(0, 999);
			if (long_hold_req) begin
				long_hold_req = 0;
				stall_left = 3000;
			end else if (stall_left == 0 && calm_left == 0) begin
				if (pick < 20) stall_left = $urandom_range(20, 200);
				else if (pick < 25) calm_left = $urandom_range(200, 600);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (calm_left > 0) begin
				calm_left--;
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) < 70);
			end
		end
	end

	// stimulus
	initial begin : stimulus
		stim_row_t   dir_tbl[$];
		normal_t     flat, none;
		int unsigned w, h;
		none = '{default: '0};
		flat = '{nx: 8'd127, ny: 8'd127, nz: 8'd255, last: 1'b0};
		width_reg = hnm_pkg::WIDTH_RESET;
		height_reg = hnm_pkg::HEIGHT_RESET;
		col_cnt = 0;
		row_cnt = 0;
		flush_cnt = 0;
		foreach (upper_h[i]) begin
			upper_h[i] = '0;
			middle_h[i] = '0;
		end

		// flat 2x2 image, early flush and extra pixel ignored
		dir_tbl.push_back('{CMD_FLUSH, 8'h00, 8'h00, 8'h00, 0, none});
		repeat (2) dir_tbl.push_back('{CMD_PIXEL, 8'h00, 8'h00, 8'h00, 0, none});
		repeat (2) dir_tbl.push_back('{CMD_PIXEL, 8'h00, 8'h00, 8'h00, 1, flat});
		dir_tbl.push_back('{CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, none});
		dir_tbl.push_back('{CMD_FLUSH, 8'h00, 8'h00, 8'h00, 1, flat});
		flat.last = 1'b1;
		dir_tbl.push_back('{CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF, 1, flat});
		// steepest slopes, each channel taking the maximum in turn
		dir_tbl.push_back('{CMD_PIXEL, 8'hFF, 8'h00, 8'h00, 0, none});
		dir_tbl.push_back('{CMD_PIXEL, 8'h00, 8'h00, 8'h00, 0, none});
		dir_tbl.push_back('{CMD_PIXEL, 8'h00, 8'h00, 8'hFF, 0, none});
		dir_tbl.push_back('{CMD_PIXEL, 8'h00, 8'hFF, 8'h00, 0, none});
		dir_tbl.push_back('{CMD_FLUSH, 8'h00, 8'h00, 8'h00, 0, none});
		dir_tbl.push_back('{CMD_FLUSH, 8'h00, 8'h00, 8'h00, 0, none});
		dir_tbl.push_back('{CMD_PIXEL, 8'h00, 8'h00, 8'h00, 0, none});
		dir_tbl.push_back('{CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, none});
		dir_tbl.push_back('{CMD_PIXEL, 8'h80, 8'h7F, 8'h01, 0, none});
		dir_tbl.push_back('{CMD_PIXEL, 8'h00, 8'h00, 8'h00, 0, none});
		dir_tbl.push_back('{CMD_FLUSH, 8'h00, 8'h00, 8'h00, 0, none});
		dir_tbl.push_back('{CMD_FLUSH, 8'h00, 8'h00, 8'h00, 0, none});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_reg(hnm_pkg::CFG_WIDTH, 16'd2);
		write_reg(hnm_pkg::CFG_HEIGHT, 16'd2);
		foreach (dir_tbl[i])
			send_item(dir_tbl[i].cmd, dir_tbl[i].r, dir_tbl[i].g, dir_tbl[i].b,
				dir_tbl[i].typed, dir_tbl[i].res);
		settle();

		// random images; the first few hit the register extremes
		while (sent_cnt < RANDOM_ITEMS) begin
			case (phase_cnt)
				0: begin w = 1; h = 1; end
				1: begin w = 0; h = 0; end
				2: begin w = 40; h = 2; end
				3: begin w = 3; h = 32'hFFFF; end
				default: begin
					w = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4)
						: $urandom_range(5, 24);
					h = $urandom_range(2, 6);
				end
			endcase
			write_reg(hnm_pkg::CFG_WIDTH, w[15:0]);
			write_reg(hnm_pkg::CFG_HEIGHT, h[15:0]);
			sender_burst = ($urandom_range(0, 3) == 0);
			if (phase_cnt == 1) long_hold_req = 1;
			if (phase_cnt == 3) begin
				// a tall image is never completed; revert it before any flush
				for (int i = 0; i < 9; i++)
					send_item(CMD_PIXEL, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, none);
				settle();
				write_reg(hnm_pkg::CFG_HEIGHT, 16'd3);
				for (int i = 0; i < 3; i++) send_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00, 0, none);
			end else begin
				w = (w < 2) ? 2 : ((w > LINE_MAX) ? LINE_MAX : w);
				h = (h < 2) ? 2 : h;
				random_image(w, h);
			end
			settle();
			phase_cnt++;
		end

		$display("Sent %0d items and checked %0d normals over %0d image configurations.",
			sent_cnt, checked_cnt, phase_cnt + 1);
		if (err_cnt == 0 && pending_normals.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#60_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
